>>> rtl/wlan_station_association_fsm_assert.svh
// Assertion macros for the station association controller RTL.
// Depends on nothing; included by the modules that carry checks.
`ifndef WLAN_STATION_ASSOCIATION_FSM_ASSERT_SVH
`define WLAN_STATION_ASSOCIATION_FSM_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define WSA_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("station association check failed");

// Next-cycle implication, disabled during reset.
`define WSA_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("station association check failed");

`endif

>>> rtl/wsa_pkg.sv
// Shared types and constants for the station association controller.
// Used by every module under rtl; depends on nothing.
`timescale 1ns / 1ps

package wsa_pkg;

  // Link state as reported on the result channel.
  typedef enum logic [2:0] {
    LS_ASSOCIATED    = 3'd0,
    LS_BEACON_MISSED = 3'd1,
    LS_WAIT_PROBE    = 3'd2,
    LS_WAIT_ASSOC    = 3'd3,
    LS_REFUSED       = 3'd4
  } link_state_t;

  // Item function codes.
  localparam logic [1:0] FUNC_TICK  = 2'd0;
  localparam logic [1:0] FUNC_TX    = 2'd1;
  localparam logic [1:0] FUNC_RECV  = 2'd2;
  localparam logic [1:0] FUNC_START = 2'd3;

  // Received frame type codes that the controller acts on.
  localparam logic [2:0] FT_DATA       = 3'd0;
  localparam logic [2:0] FT_BEACON     = 3'd3;
  localparam logic [2:0] FT_PROBE_RESP = 3'd4;
  localparam logic [2:0] FT_ASSOC_RESP = 3'd5;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_SELF_ADDRESS      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SSID_IS_BROADCAST = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_MISSED        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PROBE_TIMEOUT     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ASSOC_TIMEOUT     = 3'd4;
  localparam int unsigned CFG_DATA_W = 48;

  // Configuration reset values.
  localparam logic [7:0]  MAX_MISSED_RESET = 8'd10;
  localparam logic [31:0] TIMEOUT_RESET    = 32'd500000;

  localparam int unsigned ADDR_W  = 48;
  localparam int unsigned BI_W    = 26;
  localparam int unsigned WD_W    = 34;
  localparam int unsigned TIMER_W = 32;

  typedef struct packed {
    logic [ADDR_W-1:0]  self_address;
    logic               ssid_is_broadcast;
    logic [7:0]         max_missed_beacons;
    logic [TIMER_W-1:0] probe_timeout_us;
    logic [TIMER_W-1:0] assoc_timeout_us;
  } cfg_t;

  // One registered input transaction, with the watchdog delay already formed.
  typedef struct packed {
    logic [1:0]        func;
    logic [2:0]        frame_type;
    logic [ADDR_W-1:0] dest_addr;
    logic [ADDR_W-1:0] third_addr;
    logic              ssid_match;
    logic [WD_W-1:0]   wd_delay;
    logic              assoc_success;
  } item_t;

  typedef struct packed {
    logic              send_probe;
    logic              send_assoc;
    logic              send_data;
    logic              forward_data;
    logic              associated_event;
    logic              disassociated_event;
    link_state_t       link_state;
    logic [ADDR_W-1:0] current_bssid;
  } result_t;

endpackage

>>> rtl/wsa_cfg.sv
// Configuration register file for the station association controller.
// Depends on wsa_pkg.
`timescale 1ns / 1ps

module wsa_cfg (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [wsa_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [wsa_pkg::CFG_DATA_W-1:0]     cfg_data,
  output wsa_pkg::cfg_t                      cfg
);

  // Writes are always accepted.
  assign cfg_ready = 1'b1;

  // Register writes; indexes past the list are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.self_address       <= '0;
      cfg.ssid_is_broadcast  <= 1'b0;
      cfg.max_missed_beacons <= wsa_pkg::MAX_MISSED_RESET;
      cfg.probe_timeout_us   <= wsa_pkg::TIMEOUT_RESET;
      cfg.assoc_timeout_us   <= wsa_pkg::TIMEOUT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        wsa_pkg::CFG_SELF_ADDRESS:      cfg.self_address <= cfg_data;
        wsa_pkg::CFG_SSID_IS_BROADCAST: cfg.ssid_is_broadcast <= cfg_data[0];
        wsa_pkg::CFG_MAX_MISSED:        cfg.max_missed_beacons <= cfg_data[7:0];
        wsa_pkg::CFG_PROBE_TIMEOUT:     cfg.probe_timeout_us <= cfg_data[31:0];
        wsa_pkg::CFG_ASSOC_TIMEOUT:     cfg.assoc_timeout_us <= cfg_data[31:0];
        default: begin
        end
      endcase
    end
  end

endmodule

>>> rtl/wsa_in_stage.sv
// Input register stage: captures one transaction and forms the watchdog delay.
// Depends on wsa_pkg.
`timescale 1ns / 1ps

module wsa_in_stage (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  func,
  input  logic [2:0]                  frame_type,
  input  logic [wsa_pkg::ADDR_W-1:0]  dest_addr,
  input  logic [wsa_pkg::ADDR_W-1:0]  third_addr,
  input  logic                        ssid_match,
  input  logic [wsa_pkg::BI_W-1:0]    beacon_interval_us,
  input  logic                        assoc_success,
  input  logic [7:0]                  max_missed_beacons,
  input  logic                        advance,
  output logic                        item_valid,
  output wsa_pkg::item_t              item
);

  logic take;
  logic [wsa_pkg::WD_W-1:0] delay;

  // Hold off the source only while a captured transaction cannot move on.
  assign in_stall = item_valid && !advance;
  assign take     = in_valid && !in_stall;

  // Beacon interval times the missed-beacon limit; fits in 34 bits.
  assign delay = wsa_pkg::WD_W'(beacon_interval_us) * wsa_pkg::WD_W'(max_missed_beacons);

  // Occupancy flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (take) begin
      item_valid <= 1'b1;
    end else if (advance) begin
      item_valid <= 1'b0;
    end
  end

  // Payload capture.
  always_ff @(posedge clk) begin
    if (take) begin
      item.func          <= func;
      item.frame_type    <= frame_type;
      item.dest_addr     <= dest_addr;
      item.third_addr    <= third_addr;
      item.ssid_match    <= ssid_match;
      item.wd_delay      <= delay;
      item.assoc_success <= assoc_success;
    end
  end

endmodule

>>> rtl/wsa_core.sv
// Link state, BSSID, watchdog and retry timers, plus the result register.
// Depends on wsa_pkg and wlan_station_association_fsm_assert.svh.
`timescale 1ns / 1ps
`include "wlan_station_association_fsm_assert.svh"

module wsa_core (
  input  logic             clk,
  input  logic             rst,
  input  wsa_pkg::cfg_t    cfg,
  input  logic             item_valid,
  input  wsa_pkg::item_t   item,
  output logic             advance,
  output logic             out_valid,
  input  logic             out_stall,
  output wsa_pkg::result_t result
);

  wsa_pkg::link_state_t              link_mode, mode_next;
  logic [wsa_pkg::ADDR_W-1:0]        bssid, bssid_next;
  logic [wsa_pkg::WD_W-1:0]          wd_left, wd_left_next, wd_restart;
  logic                              wd_armed, wd_armed_next;
  logic [wsa_pkg::TIMER_W-1:0]       probe_left, probe_left_next;
  logic                              probe_armed, probe_armed_next;
  logic [wsa_pkg::TIMER_W-1:0]       assoc_left, assoc_left_next;
  logic                              assoc_armed, assoc_armed_next;
  logic                              for_us;
  wsa_pkg::result_t                  result_next;

  // A transaction moves on when the result register is free or being drained.
  assign advance = item_valid && (!out_valid || !out_stall);

  assign for_us = (item.dest_addr == cfg.self_address) || (&item.dest_addr);
  assign wd_restart = (item.wd_delay > wd_left) ? item.wd_delay : wd_left;

  // Next state and result for the transaction at the head of the input stage.
  always_comb begin
    mode_next        = link_mode;
    bssid_next       = bssid;
    wd_left_next     = wd_left;
    wd_armed_next    = wd_armed;
    probe_left_next  = probe_left;
    probe_armed_next = probe_armed;
    assoc_left_next  = assoc_left;
    assoc_armed_next = assoc_armed;
    result_next      = '0;

    case (item.func)
      wsa_pkg::FUNC_TICK: begin
        // Watchdog first, then probe retry, then association retry.
        if (wd_armed) begin
          if (wd_left <= wsa_pkg::WD_W'(1)) begin
            wd_left_next  = '0;
            wd_armed_next = 1'b0;
            mode_next     = wsa_pkg::LS_BEACON_MISSED;
          end else begin
            wd_left_next = wd_left - wsa_pkg::WD_W'(1);
          end
        end
        if (probe_armed) begin
          if (probe_left <= wsa_pkg::TIMER_W'(1)) begin
            mode_next              = wsa_pkg::LS_WAIT_PROBE;
            result_next.send_probe = 1'b1;
            probe_left_next        = cfg.probe_timeout_us;
            probe_armed_next       = 1'b1;
          end else begin
            probe_left_next = probe_left - wsa_pkg::TIMER_W'(1);
          end
        end
        if (assoc_armed) begin
          if (assoc_left <= wsa_pkg::TIMER_W'(1)) begin
            mode_next              = wsa_pkg::LS_WAIT_ASSOC;
            result_next.send_assoc = 1'b1;
            assoc_left_next        = cfg.assoc_timeout_us;
            assoc_armed_next       = 1'b1;
          end else begin
            assoc_left_next = assoc_left - wsa_pkg::TIMER_W'(1);
          end
        end
      end
      wsa_pkg::FUNC_TX: begin
        if (link_mode == wsa_pkg::LS_ASSOCIATED) begin
          result_next.send_data = 1'b1;
        end else if (link_mode == wsa_pkg::LS_BEACON_MISSED) begin
          result_next.disassociated_event = 1'b1;
          result_next.send_probe          = 1'b1;
          mode_next                       = wsa_pkg::LS_WAIT_PROBE;
          probe_left_next                 = cfg.probe_timeout_us;
          probe_armed_next                = 1'b1;
        end
      end
      wsa_pkg::FUNC_RECV: begin
        if (for_us) begin
          case (item.frame_type)
            wsa_pkg::FT_DATA: begin
              result_next.forward_data = 1'b1;
            end
            wsa_pkg::FT_BEACON: begin
              // A good beacon keeps the watchdog alive and retargets the BSSID.
              if (cfg.ssid_is_broadcast || item.ssid_match) begin
                wd_left_next  = wd_restart;
                wd_armed_next = 1'b1;
                bssid_next    = item.third_addr;
                if (link_mode == wsa_pkg::LS_BEACON_MISSED) begin
                  mode_next              = wsa_pkg::LS_WAIT_ASSOC;
                  result_next.send_assoc = 1'b1;
                  assoc_left_next        = cfg.assoc_timeout_us;
                  assoc_armed_next       = 1'b1;
                end
              end
            end
            wsa_pkg::FT_PROBE_RESP: begin
              if (link_mode == wsa_pkg::LS_WAIT_PROBE && item.ssid_match) begin
                bssid_next             = item.third_addr;
                wd_left_next           = wd_restart;
                wd_armed_next          = 1'b1;
                probe_left_next        = '0;
                probe_armed_next       = 1'b0;
                mode_next              = wsa_pkg::LS_WAIT_ASSOC;
                result_next.send_assoc = 1'b1;
                assoc_left_next        = cfg.assoc_timeout_us;
                assoc_armed_next       = 1'b1;
              end
            end
            wsa_pkg::FT_ASSOC_RESP: begin
              if (link_mode == wsa_pkg::LS_WAIT_ASSOC) begin
                assoc_left_next  = '0;
                assoc_armed_next = 1'b0;
                if (item.assoc_success) begin
                  mode_next                    = wsa_pkg::LS_ASSOCIATED;
                  result_next.associated_event = 1'b1;
                end else begin
                  mode_next = wsa_pkg::LS_REFUSED;
                end
              end
            end
            default: begin
            end
          endcase
        end
      end
      default: begin
        // Start association only acts after a missed beacon.
        if (link_mode == wsa_pkg::LS_BEACON_MISSED) begin
          result_next.disassociated_event = 1'b1;
          result_next.send_probe          = 1'b1;
          mode_next                       = wsa_pkg::LS_WAIT_PROBE;
          probe_left_next                 = cfg.probe_timeout_us;
          probe_armed_next                = 1'b1;
        end
      end
    endcase

    result_next.link_state    = mode_next;
    result_next.current_bssid = bssid_next;
  end

  // Controller state.
  always_ff @(posedge clk) begin
    if (rst) begin
      link_mode   <= wsa_pkg::LS_BEACON_MISSED;
      bssid       <= '0;
      wd_left     <= '0;
      wd_armed    <= 1'b0;
      probe_left  <= '0;
      probe_armed <= 1'b0;
      assoc_left  <= '0;
      assoc_armed <= 1'b0;
    end else if (advance) begin
      link_mode   <= mode_next;
      bssid       <= bssid_next;
      wd_left     <= wd_left_next;
      wd_armed    <= wd_armed_next;
      probe_left  <= probe_left_next;
      probe_armed <= probe_armed_next;
      assoc_left  <= assoc_left_next;
      assoc_armed <= assoc_armed_next;
    end
  end

  // Result register flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (advance) begin
      result <= result_next;
    end
  end

  // Idle timers always hold zero.
  `WSA_ASSERT_NOW(a_wd_idle_zero, clk, rst, !wd_armed, wd_left == '0)
  `WSA_ASSERT_NOW(a_probe_idle_zero, clk, rst, !probe_armed, probe_left == '0)
  `WSA_ASSERT_NOW(a_assoc_idle_zero, clk, rst, !assoc_armed, assoc_left == '0)
  // Losing the link always starts a probe.
  `WSA_ASSERT_NOW(a_disassoc_probe, clk, rst, out_valid && result.disassociated_event,
    result.send_probe && result.link_state == wsa_pkg::LS_WAIT_PROBE)
  // Data goes out only over an associated link, and that state is what was stored.
  `WSA_ASSERT_NEXT(a_data_assoc, clk, rst, advance && result_next.send_data,
    result.link_state == wsa_pkg::LS_ASSOCIATED && link_mode == wsa_pkg::LS_ASSOCIATED)

endmodule

>>> rtl/wlan_station_association_fsm.sv
// Top level of the station association controller.
// Depends on wsa_pkg, wsa_cfg, wsa_in_stage and wsa_core.
`timescale 1ns / 1ps

// Station association controller. Every input transaction (a 1 us tick, a
// transmit request, a received frame summary or a start request) yields exactly
// one result transaction carrying the frames to queue, the data forward flag, the
// association events, the link state after the transaction and the followed
// BSSID. One transaction is taken per clock cycle while the result channel does
// not stall. Each result reaches the output ports through the input register,
// then the result register, and the state update done between those two
// registers is what lets the next transaction follow directly. A stalled
// result holds the input register, which then stalls the input channel.
// Configuration writes are always accepted and are expected only while no
// transaction is in flight.
module wlan_station_association_fsm (
  input  logic                                 clk,
  input  logic                                 rst,
  // Configuration write channel.
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [wsa_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [wsa_pkg::CFG_DATA_W-1:0]       cfg_data,
  // Input channel.
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [1:0]                           func,
  input  logic [2:0]                           frame_type,
  input  logic [wsa_pkg::ADDR_W-1:0]           dest_addr,
  input  logic [wsa_pkg::ADDR_W-1:0]           third_addr,
  input  logic                                 ssid_match,
  input  logic [wsa_pkg::BI_W-1:0]             beacon_interval_us,
  input  logic                                 assoc_success,
  // Result channel.
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic                                 send_probe,
  output logic                                 send_assoc,
  output logic                                 send_data,
  output logic                                 forward_data,
  output logic                                 associated_event,
  output logic                                 disassociated_event,
  output logic [2:0]                           link_state,
  output logic [wsa_pkg::ADDR_W-1:0]           current_bssid
);

  wsa_pkg::cfg_t    cfg;
  wsa_pkg::item_t   item;
  wsa_pkg::result_t result;
  logic             item_valid;
  logic             advance;

  // Configuration registers.
  wsa_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Input register.
  wsa_in_stage u_in (
    .clk                (clk),
    .rst                (rst),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .func               (func),
    .frame_type         (frame_type),
    .dest_addr          (dest_addr),
    .third_addr         (third_addr),
    .ssid_match         (ssid_match),
    .beacon_interval_us (beacon_interval_us),
    .assoc_success      (assoc_success),
    .max_missed_beacons (cfg.max_missed_beacons),
    .advance            (advance),
    .item_valid         (item_valid),
    .item               (item)
  );

  // State update and result register.
  wsa_core u_core (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .item_valid (item_valid),
    .item       (item),
    .advance    (advance),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .result     (result)
  );

  // Result fields onto their ports.
  assign send_probe          = result.send_probe;
  assign send_assoc          = result.send_assoc;
  assign send_data           = result.send_data;
  assign forward_data        = result.forward_data;
  assign associated_event    = result.associated_event;
  assign disassociated_event = result.disassociated_event;
  assign link_state          = 3'(result.link_state);
  assign current_bssid       = result.current_bssid;

endmodule

>>> tb/tb.sv
// Self-checking testbench for the station association controller.
// Depends on wsa_pkg and wlan_station_association_fsm; it predicts every result
// from its own model of the link state, timers and watchdog.
`timescale 1ns / 1ps

module tb;

  // Frame types that the controller ignores.
  localparam logic [2:0] FT_PROBE_REQ = 3'd1;
  localparam logic [2:0] FT_ASSOC_REQ = 3'd2;
  localparam logic [2:0] FT_OTHER     = 3'd6;
  localparam logic [2:0] FT_RESERVED  = 3'd7;

  localparam logic [wsa_pkg::ADDR_W-1:0] BCAST_ADDR = '1;
  localparam logic [wsa_pkg::BI_W-1:0]   BI_MAX     = 26'd67107840;

  localparam int unsigned MAX_IDLE     = 12;
  localparam int unsigned HANG_LIMIT   = 1000;
  localparam int unsigned DRAIN_CYCLES = 4;
  localparam int unsigned TAIL_CYCLES  = 8;

  // Configuration sets used by the random phases.
  localparam int unsigned SET_MIN    = 0;
  localparam int unsigned SET_RANDOM = 1;
  localparam int unsigned SET_MAX    = 2;

  typedef struct packed {
    logic [1:0]                 func;
    logic [2:0]                 frame_type;
    logic [wsa_pkg::ADDR_W-1:0] dest_addr;
    logic [wsa_pkg::ADDR_W-1:0] third_addr;
    logic                       ssid_match;
    logic [wsa_pkg::BI_W-1:0]   beacon_interval_us;
    logic                       assoc_success;
  } station_item_t;

  logic                           clk = 1'b0;
  logic                           rst;
  logic                           cfg_valid;
  logic                           cfg_ready;
  logic [wsa_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [wsa_pkg::CFG_DATA_W-1:0] cfg_data;
  logic                           in_valid;
  logic                           in_stall;
  logic [1:0]                     func;
  logic [2:0]                     frame_type;
  logic [wsa_pkg::ADDR_W-1:0]     dest_addr;
  logic [wsa_pkg::ADDR_W-1:0]     third_addr;
  logic                           ssid_match;
  logic [wsa_pkg::BI_W-1:0]       beacon_interval_us;
  logic                           assoc_success;
  logic                           out_valid;
  logic                           out_stall;
  logic                           send_probe;
  logic                           send_assoc;
  logic                           send_data;
  logic                           forward_data;
  logic                           associated_event;
  logic                           disassociated_event;
  logic [2:0]                     link_state;
  logic [wsa_pkg::ADDR_W-1:0]     current_bssid;

  // Configuration as the controller should currently hold it.
  logic [wsa_pkg::ADDR_W-1:0]  cfg_self       = '0;
  logic                        cfg_bcast      = 1'b0;
  logic [7:0]                  cfg_max_missed = wsa_pkg::MAX_MISSED_RESET;
  logic [wsa_pkg::TIMER_W-1:0] cfg_probe_to   = wsa_pkg::TIMEOUT_RESET;
  logic [wsa_pkg::TIMER_W-1:0] cfg_assoc_to   = wsa_pkg::TIMEOUT_RESET;

  // Predicted link state, followed BSSID, watchdog and retry timers.
  wsa_pkg::link_state_t        exp_link        = wsa_pkg::LS_BEACON_MISSED;
  logic [wsa_pkg::ADDR_W-1:0]  exp_bssid       = '0;
  logic [wsa_pkg::WD_W-1:0]    wd_remaining    = '0;
  logic                        wd_running      = 1'b0;
  logic [wsa_pkg::TIMER_W-1:0] probe_remaining = '0;
  logic                        probe_running   = 1'b0;
  logic [wsa_pkg::TIMER_W-1:0] assoc_remaining = '0;
  logic                        assoc_running   = 1'b0;
  wsa_pkg::result_t            step_out;

  wsa_pkg::result_t           expected_results[$];
  int unsigned                mismatches   = 0;
  int unsigned                quiet_cycles = 0;
  bit                         in_idle_on   = 1'b1;
  bit                         out_idle_on  = 1'b1;
  logic [wsa_pkg::ADDR_W-1:0] bss_pool [4];

  wlan_station_association_fsm dut (
    .clk                 (clk),
    .rst                 (rst),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .func                (func),
    .frame_type          (frame_type),
    .dest_addr           (dest_addr),
    .third_addr          (third_addr),
    .ssid_match          (ssid_match),
    .beacon_interval_us  (beacon_interval_us),
    .assoc_success       (assoc_success),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .send_probe          (send_probe),
    .send_assoc          (send_assoc),
    .send_data           (send_data),
    .forward_data        (forward_data),
    .associated_event    (associated_event),
    .disassociated_event (disassociated_event),
    .link_state          (link_state),
    .current_bssid       (current_bssid)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic logic [wsa_pkg::ADDR_W-1:0] rand_addr();
    return {16'($urandom), $urandom};
  endfunction

  // A probe request goes out and the probe retry timer restarts.
  function automatic void launch_probe();
    exp_link = wsa_pkg::LS_WAIT_PROBE;
    step_out.send_probe = 1'b1;
    probe_remaining = cfg_probe_to;
    probe_running = 1'b1;
  endfunction

  // An association request goes out and the association retry timer restarts.
  function automatic void launch_assoc();
    exp_link = wsa_pkg::LS_WAIT_ASSOC;
    step_out.send_assoc = 1'b1;
    assoc_remaining = cfg_assoc_to;
    assoc_running = 1'b1;
  endfunction

  // The watchdog only ever moves its deadline later.
  function automatic void extend_watchdog(input logic [wsa_pkg::BI_W-1:0] interval);
    logic [wsa_pkg::WD_W-1:0] delay;
    delay = wsa_pkg::WD_W'(interval) * wsa_pkg::WD_W'(cfg_max_missed);
    if (delay > wd_remaining) wd_remaining = delay;
    wd_running = 1'b1;
  endfunction

  // Advances the predicted controller by one input transaction.
  function automatic wsa_pkg::result_t predict_association_step(input station_item_t it);
    step_out = '0;
    case (it.func)
      wsa_pkg::FUNC_TICK: begin
        // Watchdog first, then probe timer, then association timer.
        if (wd_running) begin
          if (wd_remaining <= 1) begin
            wd_remaining = '0;
            wd_running = 1'b0;
            exp_link = wsa_pkg::LS_BEACON_MISSED;
          end else begin
            wd_remaining = wd_remaining - 1'b1;
          end
        end
        if (probe_running) begin
          if (probe_remaining <= 1) begin
            probe_remaining = '0;
            probe_running = 1'b0;
            launch_probe();
          end else begin
            probe_remaining = probe_remaining - 1'b1;
          end
        end
        if (assoc_running) begin
          if (assoc_remaining <= 1) begin
            assoc_remaining = '0;
            assoc_running = 1'b0;
            launch_assoc();
          end else begin
            assoc_remaining = assoc_remaining - 1'b1;
          end
        end
      end
      wsa_pkg::FUNC_TX, wsa_pkg::FUNC_START: begin
        if (it.func == wsa_pkg::FUNC_TX && exp_link == wsa_pkg::LS_ASSOCIATED) begin
          step_out.send_data = 1'b1;
        end else if (exp_link == wsa_pkg::LS_BEACON_MISSED) begin
          step_out.disassociated_event = 1'b1;
          launch_probe();
        end
      end
      wsa_pkg::FUNC_RECV: begin
        if (it.dest_addr == cfg_self || it.dest_addr == BCAST_ADDR) begin
          case (it.frame_type)
            wsa_pkg::FT_DATA: step_out.forward_data = 1'b1;
            wsa_pkg::FT_BEACON: begin
              if (cfg_bcast || it.ssid_match) begin
                extend_watchdog(it.beacon_interval_us);
                exp_bssid = it.third_addr;
                if (exp_link == wsa_pkg::LS_BEACON_MISSED) launch_assoc();
              end
            end
            wsa_pkg::FT_PROBE_RESP: begin
              if (exp_link == wsa_pkg::LS_WAIT_PROBE && it.ssid_match) begin
                exp_bssid = it.third_addr;
                extend_watchdog(it.beacon_interval_us);
                probe_running = 1'b0;
                probe_remaining = '0;
                launch_assoc();
              end
            end
            wsa_pkg::FT_ASSOC_RESP: begin
              if (exp_link == wsa_pkg::LS_WAIT_ASSOC) begin
                assoc_running = 1'b0;
                assoc_remaining = '0;
                if (it.assoc_success) begin
                  exp_link = wsa_pkg::LS_ASSOCIATED;
                  step_out.associated_event = 1'b1;
                end else begin
                  exp_link = wsa_pkg::LS_REFUSED;
                end
              end
            end
            default: ;
          endcase
        end
      end
      default: ;
    endcase
    step_out.link_state = exp_link;
    step_out.current_bssid = exp_bssid;
    return step_out;
  endfunction

  function automatic station_item_t make_item(input logic [1:0] f, input logic [2:0] ft,
                                              input logic [wsa_pkg::ADDR_W-1:0] dest,
                                              input logic [wsa_pkg::ADDR_W-1:0] third,
                                              input logic ssid,
                                              input logic [wsa_pkg::BI_W-1:0] bi,
                                              input logic success);
    station_item_t it;
    it.func = f;
    it.frame_type = ft;
    it.dest_addr = dest;
    it.third_addr = third;
    it.ssid_match = ssid;
    it.beacon_interval_us = bi;
    it.assoc_success = success;
    return it;
  endfunction

  // Sends one input transaction and records its expected result once accepted.
  // Entered and left at a falling edge; valid stays high for a back-to-back item.
  task automatic send_item(input station_item_t it);
    int unsigned gap;
    gap = in_idle_on ? $urandom_range(0, MAX_IDLE) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    func <= it.func;
    frame_type <= it.frame_type;
    dest_addr <= it.dest_addr;
    third_addr <= it.third_addr;
    ssid_match <= it.ssid_match;
    beacon_interval_us <= it.beacon_interval_us;
    assoc_success <= it.assoc_success;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    expected_results.push_back(predict_association_step(it));
    @(negedge clk);
  endtask

  task automatic send_ticks(input int unsigned count);
    repeat (count) begin
      send_item(make_item(wsa_pkg::FUNC_TICK, wsa_pkg::FT_DATA, '0, '0, 1'b0, '0, 1'b0));
    end
  endtask

  // Holds the input side off until every expected result has arrived.
  task automatic wait_for_idle();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Writes all five registers while the controller is idle.
  task automatic load_config(input logic [wsa_pkg::ADDR_W-1:0] self_a, input logic bcast,
                             input logic [7:0] max_missed,
                             input logic [wsa_pkg::TIMER_W-1:0] probe_to,
                             input logic [wsa_pkg::TIMER_W-1:0] assoc_to);
    logic [wsa_pkg::CFG_IDX_W-1:0]  idx  [5];
    logic [wsa_pkg::CFG_DATA_W-1:0] vals [5];
    idx[0] = wsa_pkg::CFG_SELF_ADDRESS;      vals[0] = self_a;
    idx[1] = wsa_pkg::CFG_SSID_IS_BROADCAST; vals[1] = wsa_pkg::CFG_DATA_W'(bcast);
    idx[2] = wsa_pkg::CFG_MAX_MISSED;        vals[2] = wsa_pkg::CFG_DATA_W'(max_missed);
    idx[3] = wsa_pkg::CFG_PROBE_TIMEOUT;     vals[3] = wsa_pkg::CFG_DATA_W'(probe_to);
    idx[4] = wsa_pkg::CFG_ASSOC_TIMEOUT;     vals[4] = wsa_pkg::CFG_DATA_W'(assoc_to);
    wait_for_idle();
    for (int i = 0; i < 5; i++) begin
      cfg_index <= idx[i];
      cfg_data <= vals[i];
      cfg_valid <= 1'b1;
      do @(posedge clk); while (!cfg_ready);
      case (idx[i])
        wsa_pkg::CFG_SELF_ADDRESS:      cfg_self = vals[i][wsa_pkg::ADDR_W-1:0];
        wsa_pkg::CFG_SSID_IS_BROADCAST: cfg_bcast = vals[i][0];
        wsa_pkg::CFG_MAX_MISSED:        cfg_max_missed = vals[i][7:0];
        wsa_pkg::CFG_PROBE_TIMEOUT:     cfg_probe_to = vals[i][wsa_pkg::TIMER_W-1:0];
        wsa_pkg::CFG_ASSOC_TIMEOUT:     cfg_assoc_to = vals[i][wsa_pkg::TIMER_W-1:0];
        default: ;
      endcase
      @(negedge clk);
    end
    cfg_valid <= 1'b0;
  endtask

  // Walks one association through probing, refusal, watchdog loss, success,
  // data in both directions, ignored frames and a final link loss.
  task automatic test_directed_sequence();
    logic [wsa_pkg::ADDR_W-1:0] me;
    logic [wsa_pkg::ADDR_W-1:0] other;
    me = 48'h0200_1234_5678;
    other = 48'h0200_1234_5679;
    load_config(me, 1'b0, 8'd1, 32'd2, 32'd2);
    send_item(make_item(wsa_pkg::FUNC_START, wsa_pkg::FT_DATA, me, '0, 1'b0, '0, 1'b0));
    send_item(make_item(wsa_pkg::FUNC_TX, wsa_pkg::FT_DATA, other, '0, 1'b0, '0, 1'b0));
    // Probe responses that are not for us or carry the wrong SSID.
    send_item(make_item(wsa_pkg::FUNC_RECV, wsa_pkg::FT_PROBE_RESP, other, '0, 1'b1,
                        26'd3, 1'b0));
    send_item(make_item(wsa_pkg::FUNC_RECV, wsa_pkg::FT_PROBE_RESP, me, '0, 1'b0,
                        26'd3, 1'b0));
    send_item(make_item(wsa_pkg::FUNC_RECV, wsa_pkg::FT_ASSOC_RESP, me, '0, 1'b1,
                        '0, 1'b1));
    // Probe retry timer runs out and the probe is resent.
    send_ticks(2);
    send_item(make_item(wsa_pkg::FUNC_RECV, wsa_pkg::FT_PROBE_RESP, BCAST_ADDR, BCAST_ADDR,
                        1'b1, 26'd3, 1'b0));
    send_item(make_item(wsa_pkg::FUNC_RECV, wsa_pkg::FT_PROBE_RESP, me, '0, 1'b1,
                        26'd3, 1'b0));
    // Refused association; start requests and unmatched beacons do not leave it.
    send_item(make_item(wsa_pkg::FUNC_RECV, wsa_pkg::FT_ASSOC_RESP, me, '0, 1'b0,
                        '0, 1'b0));
    send_item(make_item(wsa_pkg::FUNC_START, wsa_pkg::FT_DATA, me, '0, 1'b0, '0, 1'b0));
    send_item(make_item(wsa_pkg::FUNC_RECV, wsa_pkg::FT_BEACON, me, other, 1'b0,
                        26'd9, 1'b0));
    send_ticks(3);
    // Beacon with a zero interval after the watchdog dropped the link.
    send_item(make_item(wsa_pkg::FUNC_RECV, wsa_pkg::FT_BEACON, me, '0, 1'b1, '0, 1'b0));
    send_item(make_item(wsa_pkg::FUNC_RECV, wsa_pkg::FT_ASSOC_RESP, BCAST_ADDR, '0, 1'b0,
                        '0, 1'b1));
    send_item(make_item(wsa_pkg::FUNC_TX, wsa_pkg::FT_DATA, other, '0, 1'b0, '0, 1'b0));
    send_item(make_item(wsa_pkg::FUNC_RECV, wsa_pkg::FT_DATA, BCAST_ADDR, other, 1'b0,
                        '0, 1'b0));
    send_item(make_item(wsa_pkg::FUNC_RECV, wsa_pkg::FT_DATA, other, other, 1'b0,
                        '0, 1'b0));
    send_item(make_item(wsa_pkg::FUNC_RECV, FT_PROBE_REQ, me, other, 1'b1, '0, 1'b1));
    send_item(make_item(wsa_pkg::FUNC_RECV, FT_ASSOC_REQ, me, other, 1'b1, '0, 1'b1));
    send_item(make_item(wsa_pkg::FUNC_RECV, FT_OTHER, me, other, 1'b1, '0, 1'b1));
    send_item(make_item(wsa_pkg::FUNC_RECV, FT_RESERVED, me, other, 1'b1, '0, 1'b1));
    // Zero watchdog delay expires on the next tick; transmit then re-probes.
    send_ticks(1);
    send_item(make_item(wsa_pkg::FUNC_TX, wsa_pkg::FT_DATA, other, '0, 1'b0, '0, 1'b0));
  endtask

  // Mostly well-formed management traffic aimed at this station, plus noise; the
  // minimum and random sets keep every timer and the watchdog short enough to expire.
  task automatic test_random_traffic(input int unsigned n_items, input int unsigned set_kind);
    station_item_t it;
    int unsigned   sel;
    case (set_kind)
      SET_MIN: load_config('0, 1'b0, 8'd1, 32'd1, 32'd1);
      SET_MAX: load_config(BCAST_ADDR, 1'b1, 8'd255, '1, '1);
      default: load_config(rand_addr(), 1'($urandom_range(0, 1)), 8'($urandom_range(1, 3)),
                           32'($urandom_range(1, 12)), 32'($urandom_range(1, 12)));
    endcase
    for (int unsigned i = 0; i < n_items; i++) begin
      if (i % 64 == 0) begin
        in_idle_on = $urandom_range(0, 3) != 0;
        out_idle_on = $urandom_range(0, 3) != 0;
      end
      if ($urandom_range(0, 99) == 0) wait_for_idle();
      sel = $urandom_range(0, 99);
      if (sel < 45) it.func = wsa_pkg::FUNC_TICK;
      else if (sel < 57) it.func = wsa_pkg::FUNC_TX;
      else if (sel < 65) it.func = wsa_pkg::FUNC_START;
      else it.func = wsa_pkg::FUNC_RECV;
      case ($urandom_range(0, 9))
        0, 1:    it.frame_type = wsa_pkg::FT_DATA;
        2, 3, 4: it.frame_type = wsa_pkg::FT_BEACON;
        5, 6:    it.frame_type = wsa_pkg::FT_PROBE_RESP;
        7, 8:    it.frame_type = wsa_pkg::FT_ASSOC_RESP;
        default: it.frame_type = 3'($urandom_range(0, 7));
      endcase
      sel = $urandom_range(0, 19);
      if (sel < 10) it.dest_addr = cfg_self;
      else if (sel < 17) it.dest_addr = BCAST_ADDR;
      else it.dest_addr = rand_addr();
      it.third_addr = bss_pool[$urandom_range(0, 3)];
      it.ssid_match = $urandom_range(0, 7) != 0;
      it.beacon_interval_us = wsa_pkg::BI_W'($urandom_range(0, 12));
      it.assoc_success = $urandom_range(0, 3) != 0;
      send_item(it);
    end
  endtask

  // Longest beacon intervals with the largest miss count fill the whole
  // watchdog width; run last since the watchdog then never expires.
  task automatic test_long_intervals();
    logic [wsa_pkg::ADDR_W-1:0] me;
    me = rand_addr();
    load_config(me, 1'b1, 8'd255, 32'd5, 32'd5);
    send_item(make_item(wsa_pkg::FUNC_RECV, wsa_pkg::FT_BEACON, me, rand_addr(), 1'b0,
                        26'd1023, 1'b0));
    send_item(make_item(wsa_pkg::FUNC_RECV, wsa_pkg::FT_BEACON, BCAST_ADDR, rand_addr(),
                        1'b0, BI_MAX, 1'b0));
    send_item(make_item(wsa_pkg::FUNC_RECV, wsa_pkg::FT_BEACON, me, rand_addr(), 1'b1,
                        26'd1023, 1'b0));
    send_ticks(4);
    send_item(make_item(wsa_pkg::FUNC_RECV, wsa_pkg::FT_ASSOC_RESP, me, '0, 1'b1,
                        '0, 1'b1));
    send_item(make_item(wsa_pkg::FUNC_TX, wsa_pkg::FT_DATA, rand_addr(), '0, 1'b0,
                        '0, 1'b0));
    send_item(make_item(wsa_pkg::FUNC_START, wsa_pkg::FT_DATA, me, '0, 1'b0, '0, 1'b0));
    send_ticks(6);
  endtask

  // Result side back-pressure: a random stall before each result transaction.
  initial begin : result_stall
    int unsigned hold;
    out_stall = 1'b0;
    while (rst !== 1'b0) @(negedge clk);
    forever begin
      hold = out_idle_on ? $urandom_range(0, MAX_IDLE) : 0;
      if (hold != 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  function automatic void check_field(input string name,
                                      input logic [wsa_pkg::ADDR_W-1:0] want,
                                      input logic [wsa_pkg::ADDR_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endfunction

  // Each accepted result transaction is compared with the oldest expectation.
  always @(posedge clk) begin : result_check
    wsa_pkg::result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        $error("Result transaction arrived with no expectation waiting");
        mismatches++;
      end else begin
        want = expected_results.pop_front();
        check_field("send_probe", wsa_pkg::ADDR_W'(want.send_probe),
                    wsa_pkg::ADDR_W'(send_probe));
        check_field("send_assoc", wsa_pkg::ADDR_W'(want.send_assoc),
                    wsa_pkg::ADDR_W'(send_assoc));
        check_field("send_data", wsa_pkg::ADDR_W'(want.send_data),
                    wsa_pkg::ADDR_W'(send_data));
        check_field("forward_data", wsa_pkg::ADDR_W'(want.forward_data),
                    wsa_pkg::ADDR_W'(forward_data));
        check_field("associated_event", wsa_pkg::ADDR_W'(want.associated_event),
                    wsa_pkg::ADDR_W'(associated_event));
        check_field("disassociated_event", wsa_pkg::ADDR_W'(want.disassociated_event),
                    wsa_pkg::ADDR_W'(disassociated_event));
        check_field("link_state", wsa_pkg::ADDR_W'(want.link_state),
                    wsa_pkg::ADDR_W'(link_state));
        check_field("current_bssid", want.current_bssid, current_bssid);
      end
    end
  end

  // Hang detection: too many cycles without any transaction on any channel.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= HANG_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : test_sequence
    rst = 1'b1;
    in_valid = 1'b0;
    func = wsa_pkg::FUNC_TICK;
    frame_type = wsa_pkg::FT_DATA;
    dest_addr = '0;
    third_addr = '0;
    ssid_match = 1'b0;
    beacon_interval_us = '0;
    assoc_success = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = wsa_pkg::CFG_SELF_ADDRESS;
    cfg_data = '0;
    bss_pool[0] = '0;
    bss_pool[1] = BCAST_ADDR;
    bss_pool[2] = rand_addr();
    bss_pool[3] = rand_addr();
    repeat (12) @(negedge clk);
    rst <= 1'b0;

    test_directed_sequence();
    test_random_traffic(600, SET_MIN);
    test_random_traffic(500, SET_RANDOM);
    test_random_traffic(500, SET_RANDOM);
    test_random_traffic(400, SET_MAX);
    test_long_intervals();

    wait_for_idle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+rtl
rtl/wsa_pkg.sv
rtl/wsa_cfg.sv
rtl/wsa_in_stage.sv
rtl/wsa_core.sv
rtl/wlan_station_association_fsm.sv
tb/tb.sv
